// ----- rtl/core/bpd_pkg.sv -----
package bpd_pkg;

    // Width of the largest jump offset (J-type immediate)
    localparam int unsigned OFS_W = 21;

    localparam logic [6:0]  OPC_JAL    = 7'h6F;
    localparam logic [6:0]  OPC_BRANCH = 7'h63;
    localparam logic [2:0]  CJ_FUNCT3  = 3'h5;
    localparam logic [1:0]  C_QUAD1    = 2'h1;
    localparam logic [15:0] C_RET      = 16'h8082;

    // Sequential fetch step
    localparam logic [OFS_W-1:0] SEQ_STEP = OFS_W'(4);

    typedef enum logic [1:0] {
        T_OFS_SEQ,
        T_OFS_JAL,
        T_OFS_BR,
        T_OFS_CJ
    } t_ofs_sel;

endpackage

// ----- rtl/core/branch_predecoder.sv -----
// Static next-fetch predictor. One item (fetch address, instruction word,
// compressed-valid flag, return address) is taken on each cycle that start is
// high; busy never rises, so an item may be issued every cycle. Each item gives
// exactly one result: the item is captured in an input register, decoded and
// added in one pass (one ADDR_WIDTH-bit adder), and the result is held in an
// output register, shown for one cycle with o_valid high.
// The receiver cannot stall, so it must take every result on its strobe.
// Prediction priority: JAL, backward conditional branch, C.J, C.RET, else pc+4.
module branch_predecoder
    import bpd_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_compressed_ok,
    input  logic [ADDR_WIDTH-1:0] i_fetch_addr,
    input  logic [31:0]           i_instr_word,
    input  logic [ADDR_WIDTH-1:0] i_return_addr,
    output logic                  o_valid,
    output logic                  o_taken,
    output logic [ADDR_WIDTH-1:0] o_cur_pc,
    output logic [ADDR_WIDTH-1:0] o_next_pc
);

    // Input stage
    logic                  r_in_vld;
    logic                  r_cok;
    logic [ADDR_WIDTH-1:0] r_pc;
    logic [31:0]           r_word;
    logic [ADDR_WIDTH-1:0] r_ra;

    // Decode results
    logic                  n_taken;
    logic [ADDR_WIDTH-1:0] n_next_pc;

    // Result stage
    logic                  r_out_vld;
    logic                  r_taken;
    logic [ADDR_WIDTH-1:0] r_cur_pc;
    logic [ADDR_WIDTH-1:0] r_next_pc;

    // Fully pipelined: never holds off the issuer
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cok  <= i_compressed_ok;
            r_pc   <= i_fetch_addr;
            r_word <= i_instr_word;
            r_ra   <= i_return_addr;
        end
        if (r_in_vld) begin
            r_taken   <= n_taken;
            r_cur_pc  <= r_pc;
            r_next_pc <= n_next_pc;
        end
    end

    bpd_decode #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_decode (
        .i_compressed_ok (r_cok),
        .i_fetch_addr    (r_pc),
        .i_instr_word    (r_word),
        .i_return_addr   (r_ra),
        .o_taken         (n_taken),
        .o_next_pc       (n_next_pc)
    );

    assign o_valid   = r_out_vld;
    assign o_taken   = r_taken;
    assign o_cur_pc  = r_cur_pc;
    assign o_next_pc = r_next_pc;

endmodule

// ----- rtl/core/bpd_decode.sv -----
module bpd_decode
    import bpd_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH = 64
) (
    input  logic                  i_compressed_ok,
    input  logic [ADDR_WIDTH-1:0] i_fetch_addr,
    input  logic [31:0]           i_instr_word,
    input  logic [ADDR_WIDTH-1:0] i_return_addr,
    output logic                  o_taken,
    output logic [ADDR_WIDTH-1:0] o_next_pc
);

    logic [OFS_W-1:0]      j_imm;
    logic [OFS_W-1:0]      b_imm;
    logic [OFS_W-1:0]      cj_imm;
    logic [OFS_W-1:0]      ofs;
    logic [ADDR_WIDTH-1:0] ofs_ext;
    logic                  is_jal;
    logic                  is_br;
    logic                  is_cj;
    logic                  is_cret;
    t_ofs_sel              sel;

    assign j_imm = {i_instr_word[31], i_instr_word[19:12], i_instr_word[20],
                    i_instr_word[30:21], 1'b0};
    assign b_imm = {{(OFS_W-13){i_instr_word[31]}}, i_instr_word[31], i_instr_word[7],
                    i_instr_word[30:25], i_instr_word[11:8], 1'b0};
    assign cj_imm = {{(OFS_W-12){i_instr_word[12]}}, i_instr_word[12], i_instr_word[8],
                     i_instr_word[10:9], i_instr_word[6], i_instr_word[7],
                     i_instr_word[2], i_instr_word[11], i_instr_word[5:3], 1'b0};

    assign is_jal  = (i_instr_word[6:0] == OPC_JAL);
    assign is_br   = (i_instr_word[6:0] == OPC_BRANCH) && i_instr_word[31];
    assign is_cj   = (i_instr_word[15:13] == CJ_FUNCT3) && (i_instr_word[1:0] == C_QUAD1)
                     && i_compressed_ok;
    assign is_cret = (i_instr_word[15:0] == C_RET) && i_compressed_ok;

    // Priority: JAL, backward branch, C.J; C.RET handled after the adder
    always_comb begin
        if (is_jal) begin
            sel = T_OFS_JAL;
        end else if (is_br) begin
            sel = T_OFS_BR;
        end else if (is_cj) begin
            sel = T_OFS_CJ;
        end else begin
            sel = T_OFS_SEQ;
        end
    end

    always_comb begin
        unique case (sel)
            T_OFS_JAL: ofs = j_imm;
            T_OFS_BR:  ofs = b_imm;
            T_OFS_CJ:  ofs = cj_imm;
            default:   ofs = SEQ_STEP;
        endcase
    end

    assign ofs_ext = {{(ADDR_WIDTH-OFS_W){ofs[OFS_W-1]}}, ofs};

    assign o_taken   = is_jal || is_br || is_cj || is_cret;
    assign o_next_pc = (sel == T_OFS_SEQ && is_cret) ? i_return_addr
                                                      : i_fetch_addr + ofs_ext;

endmodule

// ----- tb/branch_predecoder_tb.sv -----
module branch_predecoder_tb;
    import bpd_pkg::*;

    localparam int unsigned AW = 64;

    // One fetch item as the driver presents it, plus its pacing
    typedef struct {
        logic          cok;
        logic [AW-1:0] pc;
        logic [31:0]   word;
        logic [AW-1:0] ra;
        int            gap;     // idle cycles after this item is taken
        bit            drain;   // hold until every pending prediction is back
    } t_fetch_item;

    // What the block should report for one item
    typedef struct packed {
        logic          taken;
        logic [AW-1:0] cur_pc;
        logic [AW-1:0] next_pc;
    } t_fetch_pred;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic          i_compressed_ok = 1'b0;
    logic [AW-1:0] i_fetch_addr = '0;
    logic [31:0]   i_instr_word = '0;
    logic [AW-1:0] i_return_addr = '0;
    logic          o_valid;
    logic          o_taken;
    logic [AW-1:0] o_cur_pc;
    logic [AW-1:0] o_next_pc;

    t_fetch_item pend_items[$];
    t_fetch_pred pred_q[$];
    int          err_count = 0;
    int          gap_left = 0;

    branch_predecoder #(
        .ADDR_WIDTH(AW)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_compressed_ok(i_compressed_ok),
        .i_fetch_addr   (i_fetch_addr),
        .i_instr_word   (i_instr_word),
        .i_return_addr  (i_return_addr),
        .o_valid        (o_valid),
        .o_taken        (o_taken),
        .o_cur_pc       (o_cur_pc),
        .o_next_pc      (o_next_pc)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Static next-fetch prediction: JAL, backward branch, C.J, C.RET, else pc+4.
    function automatic t_fetch_pred predict_fetch(logic cok, logic [AW-1:0] pc,
                                                  logic [31:0] w, logic [AW-1:0] ra);
        t_fetch_pred p;
        logic [20:0] j_raw;
        logic [12:0] b_raw;
        logic [11:0] cj_raw;
        logic [AW-1:0] j_ofs, b_ofs, cj_ofs;
        logic is_jal, is_br, is_cj, is_cret;
        j_raw  = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        b_raw  = {w[31], w[7], w[30:25], w[11:8], 1'b0};
        cj_raw = {w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
        // signed size cast: sign-extends to the full address width
        j_ofs  = AW'($signed(j_raw));
        b_ofs  = AW'($signed(b_raw));
        cj_ofs = AW'($signed(cj_raw));
        is_jal  = (w[6:0] == OPC_JAL);
        is_br   = (w[6:0] == OPC_BRANCH) && w[31];
        is_cj   = (w[15:13] == CJ_FUNCT3) && (w[1:0] == C_QUAD1) && cok;
        is_cret = (w[15:0] == C_RET) && cok;
        p.taken  = is_jal || is_br || is_cj || is_cret;
        p.cur_pc = pc;
        if (is_jal)
            p.next_pc = pc + j_ofs;
        else if (is_br)
            p.next_pc = pc + b_ofs;
        else if (is_cj)
            p.next_pc = pc + cj_ofs;
        else if (is_cret)
            p.next_pc = ra;
        else
            p.next_pc = pc + AW'(4);
        return p;
    endfunction

    function automatic logic [AW-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_item(logic cok, logic [AW-1:0] pc, logic [31:0] w,
                              logic [AW-1:0] ra, int gap, bit drain);
        t_fetch_item it;
        it.cok   = cok;
        it.pc    = pc;
        it.word  = w;
        it.ra    = ra;
        it.gap   = gap;
        it.drain = drain;
        pend_items.push_back(it);
    endtask

    task automatic note_mismatch(string what, logic [AW-1:0] got, logic [AW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Driver: an item is taken on an edge with start high and busy low. After
    // that it idles for the item's gap, then presents the next pending item.
    // A drain item is held back until no prediction is outstanding.
    always @(posedge i_clk) begin
        t_fetch_item it;
        bit taken_now;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken_now = start && !busy;
            if (taken_now) begin
                pred_q.push_back(predict_fetch(i_compressed_ok, i_fetch_addr,
                                               i_instr_word, i_return_addr));
            end
            if (start && !taken_now) begin
                // block busy: keep the item on the ports
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pend_items.size() == 0) begin
                start <= 1'b0;
            end else if (pend_items[0].drain && (pred_q.size() != 0)) begin
                start <= 1'b0;
            end else begin
                it = pend_items.pop_front();
                i_compressed_ok <= it.cok;
                i_fetch_addr    <= it.pc;
                i_instr_word    <= it.word;
                i_return_addr   <= it.ra;
                start           <= 1'b1;
                gap_left        = it.gap;
            end
        end
    end

    // Monitor: every strobe is a result that must match the oldest prediction
    always @(posedge i_clk) begin
        t_fetch_pred want;
        if (i_rst_n && o_valid) begin
            if (pred_q.size() == 0) begin
                note_mismatch("unexpected result, cur_pc", o_cur_pc, '0);
            end else begin
                want = pred_q.pop_front();
                if (o_taken !== want.taken)
                    note_mismatch("taken", AW'(o_taken), AW'(want.taken));
                if (o_cur_pc !== want.cur_pc)
                    note_mismatch("cur_pc", o_cur_pc, want.cur_pc);
                if (o_next_pc !== want.next_pc)
                    note_mismatch("next_pc", o_next_pc, want.next_pc);
            end
        end
    end

    initial begin
        logic [31:0] w;
        logic [AW-1:0] pc;
        int kind;
        bit quiet;

        // Directed: immediate extremes, each jump case, address wrap
        queue_item(1'b0, '0, 32'h0000_0013, '0, 0, 1'b0);            // plain nop
        queue_item(1'b1, '1, 32'h0000_0000, '1, 0, 1'b0);            // pc+4 wraps
        queue_item(1'b1, '1, 32'hFFFF_FFFF, '0, 1, 1'b0);            // all ones word
        queue_item(1'b0, 64'h0000_0000_0010_0000, 32'h8000_006F, '0, 0, 1'b0); // JAL min
        queue_item(1'b0, '1, 32'h7FFF_FFEF, '0, 0, 1'b0);            // JAL max, wraps
        queue_item(1'b1, '0, 32'h8000_006F, '1, 2, 1'b0);            // JAL below zero
        queue_item(1'b0, 64'h1000, 32'h8000_0063, '0, 0, 1'b0);      // branch most negative
        queue_item(1'b0, '0, 32'hFFFF_FFE3, '0, 0, 1'b0);            // branch -2 from zero
        queue_item(1'b1, 64'h2000, 32'h7FFF_FFE3, '1, 0, 1'b0);      // positive branch: pc+4
        queue_item(1'b1, 64'h3000, 32'h0000_0063, '0, 3, 1'b0);      // zero branch offset
        queue_item(1'b1, 64'h4000, 32'h1234_B001, '0, 0, 1'b0);      // C.J min
        queue_item(1'b1, 64'h4000, 32'hFFFF_AFFD, '0, 0, 1'b0);      // C.J max
        queue_item(1'b1, '1, 32'h0000_BFFD, '0, 0, 1'b0);            // C.J -2
        queue_item(1'b1, 64'h5000, 32'h0000_A001, '0, 0, 1'b0);      // C.J zero offset
        queue_item(1'b0, 64'h4000, 32'hFFFF_B001, '0, 0, 1'b0);      // C.J disqualified
        queue_item(1'b1, 64'h6000, 32'h0000_8082, '1, 0, 1'b0);      // C.RET to all ones
        queue_item(1'b1, '1, 32'hFFFF_8082, '0, 1, 1'b0);            // C.RET to zero
        queue_item(1'b0, 64'h6000, 32'h0000_8082, '1, 0, 1'b0);      // C.RET disqualified
        queue_item(1'b1, 64'h7000, 32'h8082_B001, '1, 0, 1'b0);      // C.J form in low half
        queue_item(1'b1, 64'h8000, 32'h8082_806F, '1, 0, 1'b1);      // JAL, C.RET pattern in high half
        queue_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFC, 32'h0000_8082, 64'h8000_0000_0000_0000,
                   0, 1'b0);
        queue_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFC, 32'h0000_0013, '0, 0, 1'b0); // wrap to 0

        // Random: mostly well-formed jumps, the rest arbitrary words
        quiet = 1'b0;
        for (int i = 0; i < 450; i++) begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            w = $urandom;
            kind = $urandom_range(0, 19);
            if (kind < 5) begin
                w[6:0] = OPC_JAL;
            end else if (kind < 9) begin
                w[6:0] = OPC_BRANCH;
            end else if (kind < 13) begin
                w[15:13] = CJ_FUNCT3;
                w[1:0] = C_QUAD1;
            end else if (kind < 15) begin
                w[15:0] = C_RET;
            end
            pc = rand_addr();
            case ($urandom_range(0, 7))
                0: pc[AW-1:16] = '1;
                1: pc[AW-1:16] = '0;
                default: ;
            endcase
            queue_item($urandom_range(0, 3) != 0, pc, w, rand_addr(),
                       quiet ? 0 : $urandom_range(0, 8), (i % 90) == 45);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything issued and every prediction returned, then a short tail
        do
            @(posedge i_clk);
        while (pend_items.size() != 0 || start || pred_q.size() != 0);
        repeat (6) @(posedge i_clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bpd_pkg.sv
rtl/core/bpd_decode.sv
rtl/core/branch_predecoder.sv
tb/branch_predecoder_tb.sv
